// ===== rtl/qslerp_pkg.sv =====
package qslerp_pkg;

  localparam int FRAC_BITS = 14;
  localparam int Q30_SHIFT = 30;
  localparam int D30_SHIFT = Q30_SHIFT - 2 * FRAC_BITS;
  localparam int T30_SHIFT = Q30_SHIFT - FRAC_BITS;

  localparam logic [14:0] ONE_T = 15'(1 << FRAC_BITS);
  localparam logic [31:0] Q30_ONE = 32'h4000_0000;
  localparam logic [30:0] Q30_HALFPI = 31'd1686629713;

  localparam int SIN_STAGES = 16;
  localparam int ACOS_STEPS = 31;
  localparam int DIV_STEPS = 34;

  // Reciprocals of n*(n+1) for n = 14, 12, ... 2, scaled by 2^40 and rounded up.
  // With a dividend below 2^32 the scaled product gives the exact floor quotient.
  localparam int RECIP_SHIFT = 40;
  localparam logic [37:0] SIN_RECIP [7] = '{
    38'((64'd1 << 40) / 64'd210 + 64'd1),
    38'((64'd1 << 40) / 64'd156 + 64'd1),
    38'((64'd1 << 40) / 64'd110 + 64'd1),
    38'((64'd1 << 40) / 64'd72 + 64'd1),
    38'((64'd1 << 40) / 64'd42 + 64'd1),
    38'((64'd1 << 40) / 64'd20 + 64'd1),
    38'((64'd1 << 40) / 64'd6 + 64'd1)
  };

  typedef struct packed {
    logic [3:0][16:0] a;
    logic [3:0][15:0] b;
    logic [14:0]      t;
    logic             linear;
    logic [30:0]      d30;
    logic [30:0]      lo;
    logic [30:0]      hi;
    logic [30:0]      mid;
  } pipe_t;

endpackage

// ===== rtl/qslerp_sin.sv =====
module qslerp_sin (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [30:0]       x_i,
  input  qslerp_pkg::pipe_t side_i,
  output logic              valid_o,
  output logic [30:0]       sin_o,
  output qslerp_pkg::pipe_t side_o
);
  import qslerp_pkg::*;

  logic [SIN_STAGES-1:0] v_q;
  pipe_t       side_q [SIN_STAGES];
  logic [30:0] x_q [SIN_STAGES];
  logic [31:0] x2_q [SIN_STAGES];
  logic [31:0] acc_q [SIN_STAGES];

  logic [30:0] x_clamp;
  logic [61:0] sq;

  assign x_clamp = (x_i > Q30_HALFPI) ? Q30_HALFPI : x_i;
  assign sq = {31'd0, x_clamp} * {31'd0, x_clamp};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      x_q[0]    <= x_clamp;
      x2_q[0]   <= sq[61:30];
      acc_q[0]  <= Q30_ONE;
    end
  end

  // Horner's rule: odd stages multiply by x^2, even stages divide by n*(n+1)
  // and subtract from one; the last stage multiplies by x.
  for (genvar k = 1; k < SIN_STAGES; k++) begin : g_stage
    logic [31:0] acc_d;
    if (k == SIN_STAGES - 1) begin : g_final
      logic [61:0] prod;
      assign prod  = {31'd0, x_q[k-1]} * {31'd0, acc_q[k-1][30:0]};
      assign acc_d = {1'b0, prod[60:30]};
    end else if (k % 2 == 1) begin : g_mul
      logic [63:0] prod;
      assign prod  = {32'd0, x2_q[k-1]} * {32'd0, acc_q[k-1]};
      assign acc_d = prod[61:30];
    end else begin : g_div
      localparam int J = (k - 2) / 2;
      logic [69:0] prod;
      assign prod  = {38'd0, acc_q[k-1]} * {32'd0, SIN_RECIP[J]};
      assign acc_d = Q30_ONE - {2'd0, prod[69:RECIP_SHIFT]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_q[k-1];
        x_q[k]    <= x_q[k-1];
        x2_q[k]   <= x2_q[k-1];
        acc_q[k]  <= acc_d;
      end
    end
  end

  assign valid_o = v_q[SIN_STAGES-1];
  assign sin_o   = acc_q[SIN_STAGES-1][30:0];
  assign side_o  = side_q[SIN_STAGES-1];

endmodule

// ===== rtl/qslerp_acos_step.sv =====
module qslerp_acos_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  qslerp_pkg::pipe_t side_i,
  output logic              valid_o,
  output qslerp_pkg::pipe_t side_o
);
  import qslerp_pkg::*;

  logic [31:0] sum;
  logic [30:0] x;
  pipe_t       side_in;
  logic        sin_v;
  logic [30:0] sin_val;
  pipe_t       sin_side;
  pipe_t       side_d;
  logic        v_q;
  pipe_t       side_q;

  assign sum = {1'b0, side_i.lo} + {1'b0, side_i.hi} + 32'd1;
  assign x   = Q30_HALFPI - sum[31:1];

  always_comb begin
    side_in     = side_i;
    side_in.mid = sum[31:1];
  end

  qslerp_sin u_sin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (valid_i),
    .x_i     (x),
    .side_i  (side_in),
    .valid_o (sin_v),
    .sin_o   (sin_val),
    .side_o  (sin_side)
  );

  // Once the interval has closed the bounds are simply carried on.
  always_comb begin
    side_d = sin_side;
    if (sin_side.lo < sin_side.hi) begin
      if (sin_val >= sin_side.d30) begin
        side_d.lo = sin_side.mid;
      end else begin
        side_d.hi = sin_side.mid - 31'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= sin_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_d;
    end
  end

  assign valid_o = v_q;
  assign side_o  = side_q;

endmodule

// ===== rtl/qslerp_div.sv =====
module qslerp_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [30:0]       num_i,
  input  logic [30:0]       den_i,
  input  qslerp_pkg::pipe_t side_i,
  output logic              valid_o,
  output logic [33:0]       quo_o,
  output qslerp_pkg::pipe_t side_o
);
  import qslerp_pkg::*;

  logic [DIV_STEPS-1:0] v_q;
  pipe_t       side_q [DIV_STEPS];
  logic [30:0] num_q [DIV_STEPS];
  logic [30:0] den_q [DIV_STEPS];
  logic [30:0] rem_q [DIV_STEPS];
  logic [33:0] quo_q [DIV_STEPS];

  // Restoring division of num * 2^30 by den, one quotient bit per stage,
  // most significant first. The weights stay well below 2^34.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    localparam int BIT = DIV_STEPS - 1 - k;
    logic        v_in;
    pipe_t       side_in;
    logic [30:0] num_in;
    logic [30:0] den_in;
    logic [30:0] rem_in;
    logic [33:0] quo_in;
    logic        dbit;
    logic [31:0] trial;
    logic        take;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign side_in = side_i;
      assign num_in  = num_i;
      assign den_in  = den_i;
      assign rem_in  = {4'd0, num_i[30:4]};
      assign quo_in  = '0;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign side_in = side_q[k-1];
      assign num_in  = num_q[k-1];
      assign den_in  = den_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
    end

    if (BIT >= Q30_SHIFT) begin : g_numbit
      assign dbit = num_in[BIT-Q30_SHIFT];
    end else begin : g_zerobit
      assign dbit = 1'b0;
    end

    assign trial = {rem_in, dbit};
    assign take  = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        num_q[k]  <= num_in;
        den_q[k]  <= den_in;
        rem_q[k]  <= take ? 31'(trial - {1'b0, den_in}) : trial[30:0];
        quo_q[k]  <= {quo_in[32:0], take};
      end
    end
  end

  assign valid_o = v_q[DIV_STEPS-1];
  assign quo_o   = quo_q[DIV_STEPS-1];
  assign side_o  = side_q[DIV_STEPS-1];

endmodule

// ===== rtl/quaternion_slerp.sv =====
// Spherical linear interpolation of two Q2.14 quaternions. One item may be
// transferred in every clock cycle while in_stall_o is low; the latency is set
// by the arc cosine, a 31-step bisection where every step runs a 16-stage sine
// series and a result register, followed by the three sines of the weights, the
// 34-stage weight divider and the input, angle and output registers. A stall on
// the output holds the whole pipeline, so in_stall_o rises in the cycle in which
// a waiting result is not taken. The user must write near_epsilon through the
// cfg port only while no item is in flight; the block does not enforce this.
module quaternion_slerp (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [10:0] cfg_near_epsilon_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] a_x_i,
  input  logic [15:0] a_y_i,
  input  logic [15:0] a_z_i,
  input  logic [15:0] a_w_i,
  input  logic [15:0] b_x_i,
  input  logic [15:0] b_y_i,
  input  logic [15:0] b_z_i,
  input  logic [15:0] b_w_i,
  input  logic [14:0] blend_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] r_x_o,
  output logic [15:0] r_y_o,
  output logic [15:0] r_z_o,
  output logic [15:0] r_w_o,
  output logic        used_linear_o
);
  import qslerp_pkg::*;

  logic        en;
  logic [10:0] eps_q;

  logic [15:0] a_in [4];
  logic [15:0] b_in [4];
  logic signed [31:0] prod_d [4];
  logic [14:0] t_sat;

  logic        i1_v_q;
  logic [15:0] i1_a_q [4];
  logic [15:0] i1_b_q [4];
  logic [14:0] i1_t_q;
  logic signed [31:0] i1_prod_q [4];

  logic signed [33:0] dot;
  logic [33:0] dabs;
  logic signed [16:0] diff;
  logic signed [34:0] thresh;
  logic        lin_d;
  pipe_t       i2_d;
  logic        i2_v_q;
  pipe_t       i2_q;

  wire         acos_v [ACOS_STEPS+1];
  wire pipe_t  acos_p [ACOS_STEPS+1];

  logic [30:0] t30;
  logic [61:0] arg1_prod;
  logic [61:0] arg2_prod;
  logic        tr_v_q;
  pipe_t       tr_q;
  logic [30:0] arg1_q;
  logic [30:0] arg2_q;

  logic        st_v;
  logic [30:0] st;
  logic [30:0] s1;
  logic [30:0] s2;
  pipe_t       st_side;
  logic [30:0] den;

  logic        dv_v;
  logic [33:0] w1;
  logic [33:0] w2;
  pipe_t       dv_side;

  logic signed [34:0] wa;
  logic signed [34:0] wb;
  logic signed [51:0] pa_d [4];
  logic signed [51:0] pb_d [4];
  logic        f1_v_q;
  logic        f1_lin_q;
  logic signed [51:0] pa_q [4];
  logic signed [51:0] pb_q [4];

  logic [15:0] r_d [4];
  logic        out_v_q;
  logic        lin_q;
  logic [15:0] r_q [4];

  assign en          = !(out_v_q && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= 11'd1;
    end else if (cfg_valid_i) begin
      eps_q <= cfg_near_epsilon_i;
    end
  end

  // Input stage: component products and blend saturation.
  assign a_in  = '{a_x_i, a_y_i, a_z_i, a_w_i};
  assign b_in  = '{b_x_i, b_y_i, b_z_i, b_w_i};
  assign t_sat = (blend_i > ONE_T) ? ONE_T : blend_i;

  for (genvar i = 0; i < 4; i++) begin : g_dot
    assign prod_d[i] = $signed(a_in[i]) * $signed(b_in[i]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i1_v_q <= 1'b0;
    end else if (en) begin
      i1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      i1_a_q    <= a_in;
      i1_b_q    <= b_in;
      i1_t_q    <= t_sat;
      i1_prod_q <= prod_d;
    end
  end

  // Second stage: dot product, short-arc flip and path choice.
  assign dot = 34'(i1_prod_q[0]) + 34'(i1_prod_q[1]) + 34'(i1_prod_q[2])
             + 34'(i1_prod_q[3]);
  assign dabs   = dot[33] ? 34'(-dot) : dot;
  assign diff   = $signed({2'b00, ONE_T}) - $signed({6'd0, eps_q});
  assign thresh = 35'(diff) <<< FRAC_BITS;
  assign lin_d  = $signed({1'b0, dabs}) >= thresh;

  always_comb begin
    i2_d = '0;
    for (int i = 0; i < 4; i++) begin
      i2_d.a[i] = dot[33] ? 17'(-$signed({i1_a_q[i][15], i1_a_q[i]}))
                          : {i1_a_q[i][15], i1_a_q[i]};
      i2_d.b[i] = i1_b_q[i];
    end
    i2_d.t      = i1_t_q;
    i2_d.linear = lin_d;
    i2_d.d30    = lin_d ? 31'd0 : 31'(dabs << D30_SHIFT);
    i2_d.lo     = 31'd0;
    i2_d.hi     = Q30_HALFPI;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i2_v_q <= 1'b0;
    end else if (en) begin
      i2_v_q <= i1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      i2_q <= i2_d;
    end
  end

  // Arc cosine by bisection.
  assign acos_v[0] = i2_v_q;
  assign acos_p[0] = i2_q;

  for (genvar s = 0; s < ACOS_STEPS; s++) begin : g_acos
    qslerp_acos_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (acos_v[s]),
      .side_i  (acos_p[s]),
      .valid_o (acos_v[s+1]),
      .side_o  (acos_p[s+1])
    );
  end

  // Sine arguments (1-t)*theta and t*theta.
  assign t30       = 31'(acos_p[ACOS_STEPS].t) << T30_SHIFT;
  assign arg1_prod = {31'd0, acos_p[ACOS_STEPS].lo} * {31'd0, 31'(Q30_ONE) - t30};
  assign arg2_prod = {31'd0, acos_p[ACOS_STEPS].lo} * {31'd0, t30};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tr_v_q <= 1'b0;
    end else if (en) begin
      tr_v_q <= acos_v[ACOS_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tr_q   <= acos_p[ACOS_STEPS];
      arg1_q <= arg1_prod[60:30];
      arg2_q <= arg2_prod[60:30];
    end
  end

  qslerp_sin u_sin_theta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (tr_v_q),
    .x_i     (tr_q.lo),
    .side_i  (tr_q),
    .valid_o (st_v),
    .sin_o   (st),
    .side_o  (st_side)
  );

  qslerp_sin u_sin_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (tr_v_q),
    .x_i     (arg1_q),
    .side_i  (tr_q),
    .valid_o (),
    .sin_o   (s1),
    .side_o  ()
  );

  qslerp_sin u_sin_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (tr_v_q),
    .x_i     (arg2_q),
    .side_i  (tr_q),
    .valid_o (),
    .sin_o   (s2),
    .side_o  ()
  );

  // A zero sine counts as the smallest nonzero value.
  assign den = (st == 31'd0) ? 31'd1 : st;

  qslerp_div u_div_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (st_v),
    .num_i   (s1),
    .den_i   (den),
    .side_i  (st_side),
    .valid_o (dv_v),
    .quo_o   (w1),
    .side_o  (dv_side)
  );

  qslerp_div u_div_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (st_v),
    .num_i   (s2),
    .den_i   (den),
    .side_i  (st_side),
    .valid_o (),
    .quo_o   (w2),
    .side_o  ()
  );

  // Weighted sums: the linear path uses 1-t and t as weights.
  assign wa = dv_side.linear ? $signed(35'(ONE_T - dv_side.t)) : $signed({1'b0, w1});
  assign wb = dv_side.linear ? $signed(35'(dv_side.t)) : $signed({1'b0, w2});

  for (genvar i = 0; i < 4; i++) begin : g_mul
    assign pa_d[i] = $signed(dv_side.a[i]) * wa;
    assign pb_d[i] = $signed(dv_side.b[i]) * wb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
    end else if (en) begin
      f1_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_lin_q <= dv_side.linear;
      pa_q     <= pa_d;
      pb_q     <= pb_d;
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_round
    logic signed [52:0] sum;
    logic signed [52:0] rnd;
    logic signed [52:0] shifted;
    assign sum     = 53'(pa_q[i]) + 53'(pb_q[i]);
    assign rnd     = f1_lin_q ? sum + (53'sd1 <<< (FRAC_BITS - 1))
                              : sum + (53'sd1 <<< (Q30_SHIFT - 1));
    assign shifted = f1_lin_q ? (rnd >>> FRAC_BITS) : (rnd >>> Q30_SHIFT);
    always_comb begin
      if (shifted > $signed(53'(ONE_T))) begin
        r_d[i] = 16'(ONE_T);
      end else if (shifted < -$signed(53'(ONE_T))) begin
        r_d[i] = 16'(-$signed(17'(ONE_T)));
      end else begin
        r_d[i] = shifted[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= f1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lin_q <= f1_lin_q;
      r_q   <= r_d;
    end
  end

  assign out_valid_o   = out_v_q;
  assign used_linear_o = lin_q;
  assign r_x_o         = r_q[0];
  assign r_y_o         = r_q[1];
  assign r_z_o         = r_q[2];
  assign r_w_o         = r_q[3];

endmodule

// ===== rtl/qslerp_check.sv =====
module qslerp_check (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] r_x_o,
  input logic [15:0] r_y_o,
  input logic [15:0] r_z_o,
  input logic [15:0] r_w_o,
  input logic        used_linear_o
);

  // The input is held back only while a finished result waits.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a waiting result");

  // Results are saturated to the unit range.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(r_x_o) <= 16'sd16384 && $signed(r_x_o) >= -16'sd16384
                  && $signed(r_y_o) <= 16'sd16384 && $signed(r_y_o) >= -16'sd16384
                  && $signed(r_z_o) <= 16'sd16384 && $signed(r_z_o) >= -16'sd16384
                  && $signed(r_w_o) <= 16'sd16384 && $signed(r_w_o) >= -16'sd16384))
    else $error("result component out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(r_x_o) && $stable(r_y_o)
                                     && $stable(r_z_o) && $stable(r_w_o)
                                     && $stable(used_linear_o)))
    else $error("stalled result changed");

  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("result withdrawn without a transfer");

endmodule

bind quaternion_slerp qslerp_check u_qslerp_check (.*);
